// ----- hw/rtl/cpnmi_pkg.sv -----
// Shared constants, state encoding and control/status word types for the NMI unit.
package cpnmi_pkg;

    localparam int ALPHABET_DEF = 25;
    localparam int MAX_ROWS_DEF = 4096;

    localparam int SYM_W     = 5;
    localparam int NMI_W     = 17;
    localparam int LG_FRAC   = 20;
    localparam int MANT_W    = 31;
    localparam int ACC_W     = 56;
    localparam int LOG2E_Q20 = 1512775;
    localparam int ONE_Q16   = 65536;
    localparam int DIV_STEPS = 17;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_INC,
        ST_LGN_GO,
        ST_LGN_WT,
        ST_RD,
        ST_RDW,
        ST_LG_GO,
        ST_LG_WT,
        ST_TERM,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_NEXT,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_CHK,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clr;
        logic row_load;
        logic row_write;
        logic walk_init;
        logic lgn_go;
        logic lgn_take;
        logic bin_take;
        logic lg_go;
        logic lg_take;
        logic term;
        logic mul1;
        logic mul2;
        logic acc;
        logic next;
        logic fin1;
        logic fin2;
        logic fin3;
        logic chk;
        logic div;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pi_last;
        logic row_last;
        logic c_zero;
        logic lg_done;
        logic lk_last;
        logic trivial;
        logic div_last;
    } t_stat;

endpackage

// ----- hw/rtl/cpnmi_lg.sv -----
// Iterative base-2 logarithm in Q20: one mantissa squaring per cycle.
module cpnmi_lg #(
    parameter int CW = 13
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [CW-1:0]                                 i_x,
    output logic                                          o_done,
    output logic [$clog2(CW)+cpnmi_pkg::LG_FRAC-1:0]      o_res
);

    localparam int EW    = $clog2(CW);
    localparam int CNT_W = $clog2(cpnmi_pkg::LG_FRAC);
    localparam int MW    = cpnmi_pkg::MANT_W;

    logic [EW-1:0]                  e;
    logic [MW+CW-1:0]               w;
    logic [2*MW-1:0]                sq;
    logic [MW:0]                    p;
    logic [MW-1:0]                  r_m;
    logic [EW-1:0]                  r_e;
    logic [cpnmi_pkg::LG_FRAC-1:0]  r_frac;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_busy;
    logic                           r_done;

    always_comb begin
        e = '0;
        for (int k = 0; k < CW; k++) begin
            if (i_x[k]) e = EW'(k);
        end
        w  = (MW + CW)'(i_x) << (MW - 1 - int'(e));
        sq = r_m * r_m;
        p  = sq[2*MW-1:MW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(cpnmi_pkg::LG_FRAC - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(cpnmi_pkg::LG_FRAC - 1)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m    <= w[MW-1:0];
            r_e    <= e;
            r_frac <= '0;
        end else if (r_busy) begin
            // renormalize into [1,2) and shift the next fraction bit in
            if (p[MW]) begin
                r_m <= p[MW:1];
            end else begin
                r_m <= p[MW-1:0];
            end
            r_frac <= {r_frac[cpnmi_pkg::LG_FRAC-2:0], p[MW]};
        end
    end

    assign o_done = r_done;
    assign o_res  = {r_e, r_frac};

endmodule

// ----- hw/rtl/cpnmi_dp.sv -----
// Datapath: histogram memories, bin walk, log unit, accumulators and divider.
module cpnmi_dp #(
    parameter int ALPHABET = cpnmi_pkg::ALPHABET_DEF,
    parameter int MAX_ROWS = cpnmi_pkg::MAX_ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cpnmi_pkg::t_cmd              i_cmd,
    input  logic [cpnmi_pkg::SYM_W-1:0]  i_sym_a,
    input  logic [cpnmi_pkg::SYM_W-1:0]  i_sym_b,
    input  logic                         i_last,
    output cpnmi_pkg::t_stat             o_stat,
    output logic                         o_valid,
    output logic [cpnmi_pkg::NMI_W-1:0]  o_nmi
);

    localparam int AW    = $clog2(ALPHABET);
    localparam int PD    = ALPHABET * ALPHABET;
    localparam int PW    = $clog2(PD);
    localparam int CW    = $clog2(MAX_ROWS + 1);
    localparam int LG_W  = $clog2(CW) + cpnmi_pkg::LG_FRAC;
    localparam int TW    = LG_W + 2;
    localparam int BW    = PW + 1;
    localparam int KW    = PW + 2;
    localparam int XW    = ((CW > KW) ? CW : KW) + 1;
    localparam int YW    = (TW > 22) ? TW : 22;
    localparam int AC    = cpnmi_pkg::ACC_W;
    localparam int NW    = cpnmi_pkg::NMI_W;
    localparam int DW    = $clog2(cpnmi_pkg::DIV_STEPS);

    logic [CW-1:0] pair_mem [PD];
    logic [CW-1:0] a_mem [ALPHABET];
    logic [CW-1:0] b_mem [ALPHABET];

    logic [CW-1:0] r_rd_p, r_rd_a, r_rd_b;
    logic [PW-1:0] ra_p, wa_p, pa_in;
    logic [AW-1:0] ra_a, ra_b, wa_a, wa_b;
    logic [CW-1:0] wd_p, wd_a, wd_b;
    logic          we_p, we_a, we_b;

    logic [CW-1:0] r_n;
    logic [PW-1:0] r_pa, r_pi;
    logic [AW-1:0] r_aa, r_ba, r_i, r_j;
    logic          r_v, r_last;
    logic [CW-1:0] r_c, r_ca, r_cb;
    logic [1:0]    r_lk;
    logic [LG_W-1:0] r_lgn, r_lc, r_la, r_lb;
    logic signed [TW-1:0] r_t;
    logic signed [AC-1:0] r_prod, r_smi, r_sc;
    logic [BW-1:0] r_bab, r_nba, r_nbb;
    logic [AC:0]   r_rem;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_dcnt;
    logic          r_vld;
    logic [NW-1:0] r_nmi;

    logic          row_ok, i_end, j_end;
    logic [CW-1:0] lg_x;
    logic          lg_done;
    logic [LG_W-1:0] lg_res;
    logic signed [KW-1:0] k_val;
    logic signed [XW-1:0] mx;
    logic signed [YW-1:0] my;
    logic signed [AC-1:0] mprod;
    logic          num_pos, den_pos, sat, zero;
    logic [AC:0]   num_u, den2;
    logic [AC+1:0] tr, den_w;
    logic          ge;

    assign row_ok = (int'(i_sym_a) < ALPHABET) && (int'(i_sym_b) < ALPHABET)
                    && (r_n < CW'(MAX_ROWS));
    assign pa_in  = PW'(PW'(i_sym_a) * PW'(ALPHABET) + PW'(i_sym_b));
    assign i_end  = (r_i == AW'(ALPHABET - 1));
    assign j_end  = (r_j == AW'(ALPHABET - 1));

    always_comb begin
        ra_p = i_cmd.row_load ? pa_in : r_pi;
        ra_a = i_cmd.row_load ? AW'(i_sym_a) : r_i;
        ra_b = i_cmd.row_load ? AW'(i_sym_b) : r_j;

        we_p = 1'b0; wa_p = r_pi; wd_p = '0;
        we_a = 1'b0; wa_a = r_i;  wd_a = '0;
        we_b = 1'b0; wa_b = r_j;  wd_b = '0;
        if (i_cmd.row_write) begin
            we_p = r_v; wa_p = r_pa; wd_p = CW'(r_rd_p + 1'b1);
            we_a = r_v; wa_a = r_aa; wd_a = CW'(r_rd_a + 1'b1);
            we_b = r_v; wa_b = r_ba; wd_b = CW'(r_rd_b + 1'b1);
        end else if (i_cmd.bin_take) begin
            // drop each bin once it has been read
            we_p = 1'b1;
            we_a = j_end;
            we_b = i_end;
        end else if (i_cmd.clr) begin
            we_p = 1'b1;
            we_a = (r_pi < PW'(ALPHABET)); wa_a = r_pi[AW-1:0];
            we_b = (r_pi < PW'(ALPHABET)); wa_b = r_pi[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_p) pair_mem[wa_p] <= wd_p;
        r_rd_p <= pair_mem[ra_p];
    end

    always_ff @(posedge i_clk) begin
        if (we_a) a_mem[wa_a] <= wd_a;
        r_rd_a <= a_mem[ra_a];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) b_mem[wa_b] <= wd_b;
        r_rd_b <= b_mem[ra_b];
    end

    always_comb begin
        unique case (r_lk)
            2'd0:    lg_x = r_c;
            2'd1:    lg_x = r_ca;
            default: lg_x = r_cb;
        endcase
        if (i_cmd.lgn_go) lg_x = r_n;
    end

    cpnmi_lg #(
        .CW (CW)
    ) u_lg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.lgn_go | i_cmd.lg_go),
        .i_x     (lg_x),
        .o_done  (lg_done),
        .o_res   (lg_res)
    );

    assign k_val = $signed(KW'(r_bab)) - $signed(KW'(r_nba)) - $signed(KW'(r_nbb))
                   + KW'(1);

    always_comb begin
        mx = $signed(XW'(r_c));
        my = YW'(r_t);
        if (i_cmd.mul2) begin
            my = $signed(YW'(r_lc));
        end else if (i_cmd.fin1) begin
            mx = $signed(XW'(r_n));
            my = $signed(YW'(r_lgn));
        end else if (i_cmd.fin2) begin
            mx = XW'(k_val);
            my = YW'(cpnmi_pkg::LOG2E_Q20);
        end
        mprod = AC'(mx * my);
    end

    assign num_pos = !r_smi[AC-1] && (r_smi != '0);
    assign den_pos = !r_sc[AC-1] && (r_sc != '0);
    assign num_u   = {1'b0, r_smi};
    assign den2    = {r_sc, 1'b0};
    assign sat     = (num_u >= den2);
    assign zero    = (r_n == '0) || !num_pos || !den_pos;
    assign tr      = (r_dcnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign den_w   = (AC + 2)'($unsigned(r_sc));
    assign ge      = (tr >= den_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_pi   <= '0;
            r_i    <= '0;
            r_j    <= '0;
            r_lk   <= '0;
            r_last <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r_vld <= i_cmd.emit;
            if (i_cmd.clr || i_cmd.next) begin
                r_pi <= (r_pi == PW'(PD - 1)) ? '0 : PW'(r_pi + 1'b1);
            end
            if (i_cmd.next) begin
                r_j <= j_end ? '0 : AW'(r_j + 1'b1);
                if (j_end) r_i <= AW'(r_i + 1'b1);
            end
            if (i_cmd.walk_init) begin
                r_pi <= '0;
                r_i  <= '0;
                r_j  <= '0;
                r_lk <= '0;
            end
            if (i_cmd.row_load) r_last <= i_last;
            if (i_cmd.row_write && r_v) r_n <= CW'(r_n + 1'b1);
            if (i_cmd.lg_take) r_lk <= (r_lk == 2'd2) ? 2'd0 : 2'(r_lk + 1'b1);
            if (i_cmd.emit) r_n <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_load) begin
            r_v  <= row_ok;
            r_pa <= pa_in;
            r_aa <= AW'(i_sym_a);
            r_ba <= AW'(i_sym_b);
        end
        if (i_cmd.walk_init) begin
            r_bab <= '0;
            r_nba <= '0;
            r_nbb <= '0;
            r_smi <= '0;
            r_sc  <= '0;
        end
        if (i_cmd.lgn_take) r_lgn <= lg_res;
        if (i_cmd.bin_take) begin
            r_c  <= r_rd_p;
            r_ca <= r_rd_a;
            r_cb <= r_rd_b;
            if (r_rd_p != '0) r_bab <= BW'(r_bab + 1'b1);
            if ((r_j == '0) && (r_rd_a != '0)) r_nba <= BW'(r_nba + 1'b1);
            if ((r_i == '0) && (r_rd_b != '0)) r_nbb <= BW'(r_nbb + 1'b1);
        end
        if (i_cmd.lg_take) begin
            unique case (r_lk)
                2'd0:    r_lc <= lg_res;
                2'd1:    r_la <= lg_res;
                default: r_lb <= lg_res;
            endcase
        end
        if (i_cmd.term) begin
            r_t <= $signed({2'b00, r_lc}) + $signed({2'b00, r_lgn})
                   - $signed({2'b00, r_la}) - $signed({2'b00, r_lb});
        end
        if (i_cmd.mul1 || i_cmd.mul2 || i_cmd.fin1 || i_cmd.fin2) r_prod <= mprod;
        if (i_cmd.mul2) r_smi <= r_smi + r_prod;
        if (i_cmd.acc)  r_sc  <= r_sc + r_prod;
        if (i_cmd.fin2) r_sc  <= r_prod - r_sc;
        if (i_cmd.fin3) begin
            r_smi <= (r_smi <<< 1) - r_prod;
            r_sc  <= r_sc <<< 1;
        end
        if (i_cmd.chk) begin
            r_q    <= (!zero && sat) ? NW'(cpnmi_pkg::ONE_Q16) : '0;
            r_rem  <= num_u;
            r_dcnt <= '0;
        end
        if (i_cmd.div) begin
            r_rem  <= ge ? (AC + 1)'(tr - den_w) : (AC + 1)'(tr);
            r_q    <= {r_q[NW-2:0], ge};
            r_dcnt <= DW'(r_dcnt + 1'b1);
        end
        if (i_cmd.emit) begin
            r_nmi <= (r_q > NW'(cpnmi_pkg::ONE_Q16)) ? NW'(cpnmi_pkg::ONE_Q16) : r_q;
        end
    end

    assign o_stat.pi_last  = (r_pi == PW'(PD - 1));
    assign o_stat.row_last = r_last;
    assign o_stat.c_zero   = (r_rd_p == '0);
    assign o_stat.lg_done  = lg_done;
    assign o_stat.lk_last  = (r_lk == 2'd2);
    assign o_stat.trivial  = zero || sat;
    assign o_stat.div_last = (r_dcnt == DW'(cpnmi_pkg::DIV_STEPS - 1));

    assign o_valid = r_vld;
    assign o_nmi   = r_nmi;

endmodule

// ----- hw/rtl/cpnmi_ctrl.sv -----
// Controller: sequences the clearing pass, row updates, the bin walk and the final division.
module cpnmi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  cpnmi_pkg::t_stat  i_stat,
    output cpnmi_pkg::t_cmd   o_cmd,
    output logic              busy
);

    cpnmi_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpnmi_pkg::ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != cpnmi_pkg::ST_IDLE);
        unique case (r_state)
            cpnmi_pkg::ST_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.pi_last) n_state = cpnmi_pkg::ST_IDLE;
            end
            cpnmi_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.row_load = 1'b1;
                    n_state = cpnmi_pkg::ST_INC;
                end
            end
            cpnmi_pkg::ST_INC: begin
                o_cmd.row_write = 1'b1;
                if (i_stat.row_last) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = cpnmi_pkg::ST_LGN_GO;
                end else begin
                    n_state = cpnmi_pkg::ST_IDLE;
                end
            end
            cpnmi_pkg::ST_LGN_GO: begin
                o_cmd.lgn_go = 1'b1;
                n_state = cpnmi_pkg::ST_LGN_WT;
            end
            cpnmi_pkg::ST_LGN_WT: begin
                if (i_stat.lg_done) begin
                    o_cmd.lgn_take = 1'b1;
                    n_state = cpnmi_pkg::ST_RD;
                end
            end
            cpnmi_pkg::ST_RD: begin
                n_state = cpnmi_pkg::ST_RDW;
            end
            cpnmi_pkg::ST_RDW: begin
                o_cmd.bin_take = 1'b1;
                n_state = i_stat.c_zero ? cpnmi_pkg::ST_NEXT : cpnmi_pkg::ST_LG_GO;
            end
            cpnmi_pkg::ST_LG_GO: begin
                o_cmd.lg_go = 1'b1;
                n_state = cpnmi_pkg::ST_LG_WT;
            end
            cpnmi_pkg::ST_LG_WT: begin
                if (i_stat.lg_done) begin
                    o_cmd.lg_take = 1'b1;
                    n_state = i_stat.lk_last ? cpnmi_pkg::ST_TERM : cpnmi_pkg::ST_LG_GO;
                end
            end
            cpnmi_pkg::ST_TERM: begin
                o_cmd.term = 1'b1;
                n_state = cpnmi_pkg::ST_MUL1;
            end
            cpnmi_pkg::ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = cpnmi_pkg::ST_MUL2;
            end
            cpnmi_pkg::ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = cpnmi_pkg::ST_ACC;
            end
            cpnmi_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = cpnmi_pkg::ST_NEXT;
            end
            cpnmi_pkg::ST_NEXT: begin
                o_cmd.next = 1'b1;
                n_state = i_stat.pi_last ? cpnmi_pkg::ST_FIN1 : cpnmi_pkg::ST_RD;
            end
            cpnmi_pkg::ST_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state = cpnmi_pkg::ST_FIN2;
            end
            cpnmi_pkg::ST_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state = cpnmi_pkg::ST_FIN3;
            end
            cpnmi_pkg::ST_FIN3: begin
                o_cmd.fin3 = 1'b1;
                n_state = cpnmi_pkg::ST_CHK;
            end
            cpnmi_pkg::ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = i_stat.trivial ? cpnmi_pkg::ST_OUT : cpnmi_pkg::ST_DIV;
            end
            cpnmi_pkg::ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_last) n_state = cpnmi_pkg::ST_OUT;
            end
            cpnmi_pkg::ST_OUT: begin
                o_cmd.emit = 1'b1;
                n_state = cpnmi_pkg::ST_IDLE;
            end
            default: begin
                n_state = cpnmi_pkg::ST_CLR;
            end
        endcase
    end

endmodule

// ----- hw/rtl/column_pair_normalized_mi_unit.sv -----
// Top level of the column-pair normalized mutual information unit.
// Rows: a word is read in ST_IDLE and written back in ST_INC (read-modify-write); a last
// row then takes lg N and walks all ALPHABET^2 joint bins, each occupied bin with three
// log evaluations (one squaring a cycle), the term, two multiplies and the accumulate.
// The FIN and CHK states end the sums, then the 17-step divider if needed; nmi follows.
// Reset: synchronous active low; a pass clearing all histogram bins follows, busy high.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
module column_pair_normalized_mi_unit #(
    parameter int ALPHABET = cpnmi_pkg::ALPHABET_DEF,
    parameter int MAX_ROWS = cpnmi_pkg::MAX_ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cpnmi_pkg::SYM_W-1:0]  i_sym_a,
    input  logic [cpnmi_pkg::SYM_W-1:0]  i_sym_b,
    input  logic                         i_last,
    output logic                         o_valid,
    output logic [cpnmi_pkg::NMI_W-1:0]  o_nmi
);

    cpnmi_pkg::t_cmd  cmd;
    cpnmi_pkg::t_stat stat;

    // Sequence the work; the controller sees only status from the datapath.
    cpnmi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Hold the histograms, walk the bins, accumulate and divide.
    cpnmi_dp #(
        .ALPHABET (ALPHABET),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_sym_a (i_sym_a),
        .i_sym_b (i_sym_b),
        .i_last  (i_last),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_nmi   (o_nmi)
    );

    // A result word is never followed by another on the next cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // Saturation keeps the output at or below 1.0.
    a_nmi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_nmi <= cpnmi_pkg::NMI_W'(cpnmi_pkg::ONE_Q16)))
        else $error("nmi above one");

    // An accepted row word always occupies the unit for its update cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("row accepted without busy");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the column-pair normalized mutual information unit.
`timescale 1ns / 100ps

module tb_top;

    localparam int NSYM    = cpnmi_pkg::ALPHABET_DEF;
    localparam int ROW_CAP = cpnmi_pkg::MAX_ROWS_DEF;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic [cpnmi_pkg::SYM_W-1:0] a;
        logic [cpnmi_pkg::SYM_W-1:0] b;
        logic                        last;
    } t_row_word;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [cpnmi_pkg::SYM_W-1:0] i_sym_a;
    logic [cpnmi_pkg::SYM_W-1:0] i_sym_b;
    logic                        i_last;
    logic                        o_valid;
    logic [cpnmi_pkg::NMI_W-1:0] o_nmi;

    column_pair_normalized_mi_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sym_a (i_sym_a),
        .i_sym_b (i_sym_b),
        .i_last  (i_last),
        .o_valid (o_valid),
        .o_nmi   (o_nmi)
    );

    // Free-running clock, 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Pending row words, filled up front and drained by the driver.
    t_row_word row_queue[$];
    // Expected nmi values, oldest first.
    logic [cpnmi_pkg::NMI_W-1:0] nmi_expected[$];

    int          errors;
    int          words_sent;
    logic        took;
    int          stall_cycles;

    // Shadow histograms mirroring the block's state.
    int unsigned hist_pair[NSYM*NSYM];
    int unsigned hist_a[NSYM];
    int unsigned hist_b[NSYM];
    int unsigned rows_seen;

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // log2 of a count in unsigned Q20 by repeated squaring of the mantissa.
    function automatic longint log2_q20(input int unsigned x);
        int unsigned e;
        int unsigned t;
        bit [63:0]   m;
        bit [63:0]   frac;
        e = 0;
        t = x;
        frac = 0;
        if (x == 0)
            return 0;
        while (t > 1) begin
            t = t >> 1;
            e++;
        end
        if (e > 30)
            e = 30;
        m = ({32'd0, x} << (30 - e)) & 64'hFFFF_FFFF;
        for (int i = cpnmi_pkg::LG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return longint'((64'(e) << cpnmi_pkg::LG_FRAC) | frac);
    endfunction

    // Corrected MI over joint entropy, Q16, from the shadow histograms.
    function automatic logic [cpnmi_pkg::NMI_W-1:0] nmi_of_hist();
        longint n, lgn, smi, sc, sh, num, den, bab, ba, bb, k, q, c, lc;
        n = rows_seen;
        lgn = log2_q20(rows_seen);
        smi = 0;
        sc = 0;
        bab = 0;
        ba = 0;
        bb = 0;
        for (int i = 0; i < NSYM; i++) begin
            if (hist_a[i] > 0) ba++;
            if (hist_b[i] > 0) bb++;
        end
        for (int i = 0; i < NSYM; i++) begin
            for (int j = 0; j < NSYM; j++) begin
                c = hist_pair[i*NSYM+j];
                if (c != 0) begin
                    bab++;
                    lc = log2_q20(c);
                    smi += c * (lc + lgn - log2_q20(hist_a[i]) - log2_q20(hist_b[j]));
                    sc += c * lc;
                end
            end
        end
        sh = n * lgn - sc;
        k = bab - ba - bb + 1;
        num = 2 * smi - k * longint'(cpnmi_pkg::LOG2E_Q20);
        den = 2 * sh;
        if (n == 0 || num <= 0 || den <= 0)
            return '0;
        q = (num * longint'(cpnmi_pkg::ONE_Q16)) / den;
        if (q > cpnmi_pkg::ONE_Q16)
            q = cpnmi_pkg::ONE_Q16;
        return q[cpnmi_pkg::NMI_W-1:0];
    endfunction

    // Advance the shadow state by one accepted row word.
    task automatic absorb_row(input logic [cpnmi_pkg::SYM_W-1:0] a,
                              input logic [cpnmi_pkg::SYM_W-1:0] b,
                              input logic last);
        if (a < NSYM && b < NSYM && rows_seen < ROW_CAP) begin
            hist_pair[a*NSYM+b]++;
            hist_a[a]++;
            hist_b[b]++;
            rows_seen++;
        end
        if (last) begin
            nmi_expected.push_back(nmi_of_hist());
            foreach (hist_pair[i]) hist_pair[i] = 0;
            foreach (hist_a[i]) hist_a[i] = 0;
            foreach (hist_b[i]) hist_b[i] = 0;
            rows_seen = 0;
        end
    endtask

    task automatic push_row(input int a, input int b, input bit last);
        t_row_word w;
        w.a = cpnmi_pkg::SYM_W'(a);
        w.b = cpnmi_pkg::SYM_W'(b);
        w.last = last;
        row_queue.push_back(w);
    endtask

    // One column pair: symbols drawn from a window of span values, some rows
    // tied so that the columns share information, a few out-of-range symbols.
    task automatic push_pair(input int len, input int span, input int tie_pct,
                             input int noise_pct);
        int base, a, b;
        base = $urandom_range(NSYM - span, 0);
        for (int r = 0; r < len; r++) begin
            a = base + $urandom_range(span - 1, 0);
            b = ($urandom_range(99, 0) < tie_pct) ? a : base + $urandom_range(span - 1, 0);
            if ($urandom_range(99, 0) < noise_pct) begin
                if ($urandom_range(1, 0)) a = $urandom_range(31, NSYM);
                else b = $urandom_range(31, NSYM);
            end
            push_row(a, b, r == len - 1);
        end
    endtask

    // Driver: present a new word at the falling edge once the previous one
    // was taken; idle according to the current phase.
    always @(negedge i_clk) begin
        int pct;
        t_row_word w;
        case ((words_sent / 250) % 4)
            0: pct = 0;
            1: pct = 67;
            2: pct = 0;
            default: pct = 35;
        endcase
        if (i_rst_n && (!start || took)) begin
            if (row_queue.size() > 0 && $urandom_range(99, 0) >= pct) begin
                w = row_queue.pop_front();
                start   <= 1'b1;
                i_sym_a <= w.a;
                i_sym_b <= w.b;
                i_last  <= w.last;
                words_sent++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: sample handshakes at the rising edge, predict and check.
    always @(posedge i_clk) begin
        logic [cpnmi_pkg::NMI_W-1:0] want;
        if (!i_rst_n) begin
            took <= 1'b0;
            stall_cycles <= 0;
        end else begin
            took <= start && !busy;
            if (start && !busy)
                absorb_row(i_sym_a, i_sym_b, i_last);
            if (o_valid) begin
                if (nmi_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected nmi %0d", o_nmi));
                end else begin
                    want = nmi_expected.pop_front();
                    if (o_nmi !== want)
                        report_mismatch($sformatf("nmi got %0d want %0d", o_nmi, want));
                end
            end
            // Watchdog: count cycles in which no word moves either way.
            if ((start && !busy) || o_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog expired");
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        words_sent = 0;
        took = 1'b0;
        stall_cycles = 0;
        rows_seen = 0;
        foreach (hist_pair[i]) hist_pair[i] = 0;
        foreach (hist_a[i]) hist_a[i] = 0;
        foreach (hist_b[i]) hist_b[i] = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_sym_a = '0;
        i_sym_b = '0;
        i_last  = 1'b0;

        // Directed: last with nothing counted (out-of-range symbols only).
        push_row(31, 0, 1);
        push_row(0, 31, 1);
        // Single occupied bin: zero entropy.
        push_row(24, 24, 1);
        push_row(0, 0, 0);
        push_row(0, 0, 1);
        // Perfect dependence on a diagonal: ratio above one, saturates.
        push_row(0, 0, 0);
        push_row(7, 7, 0);
        push_row(16, 16, 0);
        push_row(24, 24, 1);
        // Independent columns: correction drives MI negative.
        push_row(0, 0, 0);
        push_row(0, 24, 0);
        push_row(24, 0, 0);
        push_row(24, 24, 1);
        // Mixed, with out-of-range symbols dropped mid-pair.
        push_row(3, 12, 0);
        push_row(25, 5, 0);
        push_row(3, 12, 0);
        push_row(10, 30, 0);
        push_row(19, 1, 0);
        push_row(19, 2, 1);

        // Random pairs, mostly small windows so that shared information shows.
        while (row_queue.size() < 450)
            push_pair($urandom_range(40, 1), $urandom_range(6, 1),
                      $urandom_range(100, 0), $urandom_range(10, 0));
        // One pair spread over the whole joint table.
        push_pair(250, NSYM, 0, 2);
        while (row_queue.size() < 1000)
            push_pair($urandom_range(30, 1), $urandom_range(NSYM, 1),
                      $urandom_range(100, 0), 5);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain: wait for every word to go in and every nmi to come back.
        while (row_queue.size() > 0 || start || nmi_expected.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
